// ===== design/sqoa_pkg.sv =====
// Shared constants and types for the square oscillator with ADSR envelope.
`timescale 1ns / 1ps

package sqoa_pkg;

	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned StepW    = 15;
	localparam int unsigned LevelW   = 16;
	localparam int unsigned PhaseW   = 16;
	localparam int unsigned SampleW  = LevelW + 1;

	// register indexes on the configuration port
	localparam logic [CfgIdxW-1:0] CFG_PHASE_STEP      = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_ATTACK_STEP     = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_PEAK_LEVEL      = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_DECAY_STEP      = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_SUSTAIN_LEVEL   = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_SUSTAIN_BUFFERS = 3'd5;
	localparam logic [CfgIdxW-1:0] CFG_RELEASE_STEP    = 3'd6;

	// reset values
	localparam logic [StepW-1:0]  RST_PHASE_STEP      = 15'd328;
	localparam logic [LevelW-1:0] RST_ATTACK_STEP     = 16'd1638;
	localparam logic [LevelW-1:0] RST_PEAK_LEVEL      = 16'd16384;
	localparam logic [LevelW-1:0] RST_DECAY_STEP      = 16'd164;
	localparam logic [LevelW-1:0] RST_SUSTAIN_LEVEL   = 16'd14746;
	localparam logic [LevelW-1:0] RST_SUSTAIN_BUFFERS = 16'd300;
	localparam logic [LevelW-1:0] RST_RELEASE_STEP    = 16'd1638;

	typedef struct packed {
		logic [StepW-1:0]  phase_step;
		logic [LevelW-1:0] attack_step;
		logic [LevelW-1:0] peak_level;
		logic [LevelW-1:0] decay_step;
		logic [LevelW-1:0] sustain_level;
		logic [LevelW-1:0] sustain_buffers;
		logic [LevelW-1:0] release_step;
	} cfg_t;

	// load of the sustain countdown that goes with a sustain_buffers write
	typedef struct packed {
		logic              load;
		logic [LevelW-1:0] value;
	} sus_load_t;

endpackage

// ===== design/sqoa_cfg_regs.sv =====
// Configuration register bank of the square oscillator with ADSR envelope.
`timescale 1ns / 1ps

module sqoa_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [sqoa_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [sqoa_pkg::CfgDataW-1:0]      cfg_data,
	output sqoa_pkg::cfg_t                     cfg,
	output sqoa_pkg::sus_load_t                sus_load
);

	sqoa_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_step      <= sqoa_pkg::RST_PHASE_STEP;
			cfg_q.attack_step     <= sqoa_pkg::RST_ATTACK_STEP;
			cfg_q.peak_level      <= sqoa_pkg::RST_PEAK_LEVEL;
			cfg_q.decay_step      <= sqoa_pkg::RST_DECAY_STEP;
			cfg_q.sustain_level   <= sqoa_pkg::RST_SUSTAIN_LEVEL;
			cfg_q.sustain_buffers <= sqoa_pkg::RST_SUSTAIN_BUFFERS;
			cfg_q.release_step    <= sqoa_pkg::RST_RELEASE_STEP;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sqoa_pkg::CFG_PHASE_STEP:      cfg_q.phase_step <= cfg_data[sqoa_pkg::StepW-1:0];
				sqoa_pkg::CFG_ATTACK_STEP:     cfg_q.attack_step     <= cfg_data;
				sqoa_pkg::CFG_PEAK_LEVEL:      cfg_q.peak_level      <= cfg_data;
				sqoa_pkg::CFG_DECAY_STEP:      cfg_q.decay_step      <= cfg_data;
				sqoa_pkg::CFG_SUSTAIN_LEVEL:   cfg_q.sustain_level   <= cfg_data;
				sqoa_pkg::CFG_SUSTAIN_BUFFERS: cfg_q.sustain_buffers <= cfg_data;
				sqoa_pkg::CFG_RELEASE_STEP:    cfg_q.release_step    <= cfg_data;
				default: ; // drop writes to unused indexes
			endcase
		end
	end

	assign cfg            = cfg_q;
	assign sus_load.load  = cfg_we && (cfg_index == sqoa_pkg::CFG_SUSTAIN_BUFFERS);
	assign sus_load.value = cfg_data;

endmodule

// ===== design/sqoa_envelope.sv =====
// ADSR envelope state and its per-buffer update.
`timescale 1ns / 1ps

module sqoa_envelope (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             upd_en,
	input  sqoa_pkg::cfg_t                   cfg,
	input  sqoa_pkg::sus_load_t              sus_load,
	output logic [sqoa_pkg::LevelW-1:0]      level
);

	typedef enum logic [1:0] {
		MODE_ATTACK,
		MODE_DECAY,
		MODE_SUSTAIN,
		MODE_RELEASE
	} mode_t;

	mode_t                        mode_q, mode_d;
	logic [sqoa_pkg::LevelW-1:0]  level_q, level_d;
	logic [sqoa_pkg::LevelW-1:0]  left_q, left_d;

	// the checks run in order, so a mode entered early is acted on later
	always_comb begin
		logic [sqoa_pkg::LevelW:0]   sum;
		logic [sqoa_pkg::LevelW-1:0] lvl1, lvl2;
		mode_t                       m1, m2;

		sum  = {1'b0, level_q} + {1'b0, cfg.attack_step};
		lvl1 = level_q;
		if (mode_q == MODE_ATTACK && level_q < cfg.peak_level)
			lvl1 = sum[sqoa_pkg::LevelW] ? '1 : sum[sqoa_pkg::LevelW-1:0];
		m1 = (mode_q == MODE_ATTACK && lvl1 >= cfg.peak_level) ? MODE_DECAY : mode_q;

		lvl2 = lvl1;
		if (m1 == MODE_DECAY && lvl1 > cfg.sustain_level)
			lvl2 = (lvl1 > cfg.decay_step) ? lvl1 - cfg.decay_step : '0;
		m2 = (m1 == MODE_DECAY && lvl2 <= cfg.sustain_level) ? MODE_SUSTAIN : m1;

		left_d = left_q;
		if (m2 == MODE_SUSTAIN && left_q != '0)
			left_d = left_q - 1'b1;
		mode_d = (m2 == MODE_SUSTAIN && left_d == '0) ? MODE_RELEASE : m2;

		level_d = lvl2;
		if (mode_d == MODE_RELEASE && lvl2 != '0)
			level_d = (lvl2 > cfg.release_step) ? lvl2 - cfg.release_step : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_ATTACK;
			level_q <= '0;
			left_q  <= sqoa_pkg::RST_SUSTAIN_BUFFERS;
		end else begin
			if (upd_en) begin
				mode_q  <= mode_d;
				level_q <= level_d;
			end
			if (sus_load.load)
				left_q <= sus_load.value;
			else if (upd_en)
				left_q <= left_d;
		end
	end

	assign level = level_q;

endmodule

// ===== design/square_oscillator_adsr_envelope.sv =====
// Top level: square-wave oscillator shaped by an ADSR envelope.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_ready, end_of_buffer): one transaction per
//   stereo frame request. Output channel (out_valid/out_ready, left_sample,
//   right_sample): one transaction per frame, Q3.14 signed, right = -left.
//   Latency: a frame accepted at one edge shows its samples on the output
//   from the next cycle. Throughput: one frame per cycle while out_ready is
//   high, set by the single output register; the phase add and the envelope
//   update both complete in the accept cycle.
//   Stall: while the output register holds an untaken result, in_ready
//   follows out_ready, so a frame is taken in the same cycle the held
//   result leaves; with out_ready low nothing moves and state holds.
//   end_of_buffer = 1 runs one envelope update after the frame's samples.
//   Configuration: cfg_we/cfg_index/cfg_data write a register at once;
//   write only while idle. A sustain_buffers write also reloads the sustain
//   countdown.
//   Reset: phase and envelope level clear, mode returns to attack, the
//   registers take their defaults and the output register empties.
module square_oscillator_adsr_envelope (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [sqoa_pkg::CfgIdxW-1:0]           cfg_index,
	input  logic [sqoa_pkg::CfgDataW-1:0]          cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   end_of_buffer,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [sqoa_pkg::SampleW-1:0]    left_sample,
	output logic signed [sqoa_pkg::SampleW-1:0]    right_sample
);

	sqoa_pkg::cfg_t                       cfg;
	sqoa_pkg::sus_load_t                  sus_load;
	logic [sqoa_pkg::LevelW-1:0]          level;
	logic [sqoa_pkg::PhaseW-1:0]          phase_q;
	logic                                 out_valid_q;
	logic [sqoa_pkg::SampleW-1:0]         left_q, right_q;
	logic [sqoa_pkg::SampleW-1:0]         pos, neg;
	logic                                 accept;

	sqoa_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.sus_load  (sus_load)
	);

	// the envelope advances only on an accepted end-of-buffer frame
	sqoa_envelope u_env (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd_en   (accept && end_of_buffer),
		.cfg      (cfg),
		.sus_load (sus_load),
		.level    (level)
	);

	// take a new frame whenever the output slot is empty or being emptied
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// samples come from the state before this frame's update
	assign pos = {1'b0, level};
	assign neg = '0 - pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				phase_q <= phase_q + {1'b0, cfg.phase_step};
			if (accept)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// payload needs no reset: qualified by out_valid_q
	always_ff @(posedge clk) begin
		if (accept) begin
			left_q  <= phase_q[sqoa_pkg::PhaseW-1] ? pos : neg;
			right_q <= phase_q[sqoa_pkg::PhaseW-1] ? neg : pos;
		end
	end

	assign out_valid    = out_valid_q;
	assign left_sample  = left_q;
	assign right_sample = right_q;

	// right channel is always the exact negation of the left
	a_stereo_negated: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (right_q == ('0 - left_q)))
		else $error("right sample is not the negation of the left");

	// an empty output slot must never block the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with an empty output register");

	// every accepted frame leaves a result in the output register
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted frame produced no result");

	// phase moves only with an accepted frame
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(phase_q))
		else $error("phase advanced without a frame");

endmodule

// ===== bench/tb.sv =====
// Testbench for the square-wave oscillator with ADSR envelope: stimulus, prediction and checks.
`timescale 1ns / 1ps

module tb;

	// index that maps to no register; a write to it must leave everything alone
	localparam logic [sqoa_pkg::CfgIdxW-1:0] CFG_UNMAPPED = 3'd7;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned HOLD_CYCLES  = 80;
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam int unsigned MAX_REPORTS  = 10;
	localparam int unsigned RESET_CYCLES = 9;

	typedef enum logic [1:0] {
		ENV_ATTACK,
		ENV_DECAY,
		ENV_SUSTAIN,
		ENV_RELEASE
	} env_mode_t;

	typedef struct packed {
		logic signed [sqoa_pkg::SampleW-1:0] left_val;
		logic signed [sqoa_pkg::SampleW-1:0] right_val;
	} stereo_frame_t;

	// ports of the block; every input holds a known value from time zero
	logic                                clk           = 1'b0;
	logic                                arst_n        = 1'b0;
	logic                                cfg_we        = 1'b0;
	logic [sqoa_pkg::CfgIdxW-1:0]        cfg_index     = '0;
	logic [sqoa_pkg::CfgDataW-1:0]       cfg_data      = '0;
	logic                                in_valid      = 1'b0;
	logic                                end_of_buffer = 1'b0;
	logic                                out_ready     = 1'b0;
	logic                                in_ready;
	logic                                out_valid;
	logic signed [sqoa_pkg::SampleW-1:0] left_sample;
	logic signed [sqoa_pkg::SampleW-1:0] right_sample;

	// the predictor's own copy of the registers and the tone state
	sqoa_pkg::cfg_t tone_cfg = '{
		phase_step:      sqoa_pkg::RST_PHASE_STEP,
		attack_step:     sqoa_pkg::RST_ATTACK_STEP,
		peak_level:      sqoa_pkg::RST_PEAK_LEVEL,
		decay_step:      sqoa_pkg::RST_DECAY_STEP,
		sustain_level:   sqoa_pkg::RST_SUSTAIN_LEVEL,
		sustain_buffers: sqoa_pkg::RST_SUSTAIN_BUFFERS,
		release_step:    sqoa_pkg::RST_RELEASE_STEP
	};
	logic [sqoa_pkg::PhaseW-1:0] phase_acc     = '0;
	logic [sqoa_pkg::LevelW-1:0] env_level     = '0;
	env_mode_t                   env_mode      = ENV_ATTACK;
	logic [sqoa_pkg::LevelW-1:0] sustain_count = sqoa_pkg::RST_SUSTAIN_BUFFERS;

	// frames waiting to be offered, and samples waiting to come out
	logic          pending_eob[$];
	stereo_frame_t expected_frames[$];
	stereo_frame_t want;

	// traffic shaping, set per phase by the stimulus process
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	logic        stall_request  = 1'b0;
	logic        stall_served   = 1'b0;
	int unsigned hold_left      = 0;

	int unsigned mismatches  = 0;
	int unsigned cycle_count = 0;

	square_oscillator_adsr_envelope dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.end_of_buffer(end_of_buffer),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.left_sample  (left_sample),
		.right_sample (right_sample)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Form the samples of one frame from the current phase and level, then
	// advance the phase and, on the last frame of a buffer, run one envelope
	// update. The stages run in order, so a mode entered in one stage is acted
	// on by the next stage of the same update.
	function automatic stereo_frame_t next_stereo_frame(input logic eob);
		stereo_frame_t                frame;
		logic [sqoa_pkg::SampleW-1:0] level_pos;
		logic [sqoa_pkg::SampleW-1:0] level_neg;
		logic [sqoa_pkg::LevelW:0]    level_sum;
		level_pos       = {1'b0, env_level};
		level_neg       = -level_pos;
		frame.left_val  = phase_acc[sqoa_pkg::PhaseW-1] ? level_pos : level_neg;
		frame.right_val = phase_acc[sqoa_pkg::PhaseW-1] ? level_neg : level_pos;
		// wrap in two's complement: +1.0 folds over to -1.0
		phase_acc = phase_acc + sqoa_pkg::PhaseW'(tone_cfg.phase_step);
		if (eob) begin
			if (env_mode == ENV_ATTACK && env_level < tone_cfg.peak_level) begin
				level_sum = env_level + tone_cfg.attack_step;
				// saturate rather than wrap
				env_level = level_sum[sqoa_pkg::LevelW] ? '1 :
					level_sum[sqoa_pkg::LevelW-1:0];
			end
			if (env_mode == ENV_ATTACK && env_level >= tone_cfg.peak_level)
				env_mode = ENV_DECAY;
			if (env_mode == ENV_DECAY && env_level > tone_cfg.sustain_level)
				env_level = (env_level > tone_cfg.decay_step) ?
					env_level - tone_cfg.decay_step : '0;
			if (env_mode == ENV_DECAY && env_level <= tone_cfg.sustain_level)
				env_mode = ENV_SUSTAIN;
			if (env_mode == ENV_SUSTAIN && sustain_count != 0)
				sustain_count = sustain_count - 1'b1;
			if (env_mode == ENV_SUSTAIN && sustain_count == 0)
				env_mode = ENV_RELEASE;
			// clamp at zero; once there the level stays put in release
			if (env_mode == ENV_RELEASE && env_level != 0)
				env_level = (env_level > tone_cfg.release_step) ?
					env_level - tone_cfg.release_step : '0;
		end
		return frame;
	endfunction

	// Sender: predict each accepted frame, then offer the next pending one,
	// or idle at random while the slot is free. Valid is never withdrawn
	// before its transaction completes.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid      <= 1'b0;
			end_of_buffer <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				expected_frames.push_back(next_stereo_frame(end_of_buffer));
			if (!in_valid || in_ready) begin
				if (pending_eob.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid      <= 1'b1;
					end_of_buffer <= pending_eob.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall at random, and once on request hold off for a long
	// stretch so that the output register fills and the input backs up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (stall_request && !stall_served) begin
			out_ready    <= 1'b0;
			hold_left    <= HOLD_CYCLES;
			stall_served <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Checker: every output transaction against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_frames.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("unexpected frame at %0t: left %0d right %0d",
						$time, left_sample, right_sample);
				mismatches++;
			end else begin
				want = expected_frames.pop_front();
				if (left_sample !== want.left_val || right_sample !== want.right_val) begin
					if (mismatches < MAX_REPORTS)
						$display("frame mismatch at %0t: expected %0d/%0d, got %0d/%0d",
							$time, want.left_val, want.right_val,
							left_sample, right_sample);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: give up well past the slowest correct run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Write one register while idle and mirror it into the predictor. A write
	// to the sustain count also reloads the running countdown.
	task automatic write_register(input logic [sqoa_pkg::CfgIdxW-1:0] idx,
			input logic [sqoa_pkg::CfgDataW-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			sqoa_pkg::CFG_PHASE_STEP:
				tone_cfg.phase_step = data[sqoa_pkg::StepW-1:0];
			sqoa_pkg::CFG_ATTACK_STEP:   tone_cfg.attack_step   = data;
			sqoa_pkg::CFG_PEAK_LEVEL:    tone_cfg.peak_level    = data;
			sqoa_pkg::CFG_DECAY_STEP:    tone_cfg.decay_step    = data;
			sqoa_pkg::CFG_SUSTAIN_LEVEL: tone_cfg.sustain_level = data;
			sqoa_pkg::CFG_SUSTAIN_BUFFERS: begin
				tone_cfg.sustain_buffers = data;
				sustain_count            = data;
			end
			sqoa_pkg::CFG_RELEASE_STEP:  tone_cfg.release_step  = data;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Hold the stimulus until every frame has gone in and every sample out.
	task automatic drain_frames();
		do
			@(posedge clk);
		while (pending_eob.size() != 0 || in_valid || expected_frames.size() != 0);
	endtask

	// Queue random frames, one in eob_odds closing a buffer, under the given
	// idling, and wait for the lot to come back.
	task automatic play_frames(input int unsigned count, input int unsigned eob_odds,
			input int unsigned send_pct, input int unsigned recv_pct);
		send_idle_pct  <= send_pct;
		recv_stall_pct <= recv_pct;
		for (int unsigned n = 0; n < count; n++)
			pending_eob.push_back($urandom_range(eob_odds - 1) == 0);
		drain_frames();
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: a steep attack into a peak at full scale, so the sum
		// saturates and attack hands over to decay in the update that saturates; the
		// other registers keep their reset values. Alternate end_of_buffer.
		write_register(sqoa_pkg::CFG_ATTACK_STEP, 16'd40000);
		write_register(sqoa_pkg::CFG_PEAK_LEVEL, 16'hFFFF);
		for (int unsigned n = 0; n < 24; n++)
			pending_eob.push_back(n[0]);
		drain_frames();

		// Full-scale phase step (the spare top bit of the data must be
		// dropped); a zero decay step pins the level high in decay.
		write_register(sqoa_pkg::CFG_PHASE_STEP, 16'hFFFF);
		write_register(sqoa_pkg::CFG_DECAY_STEP, 16'd0);
		write_register(sqoa_pkg::CFG_SUSTAIN_LEVEL, 16'd0);
		write_register(sqoa_pkg::CFG_RELEASE_STEP, 16'd0);
		write_register(sqoa_pkg::CFG_ATTACK_STEP, 16'hFFFF);
		play_frames(250, 16, 0, 0);

		// Decay down to a random sustain level and settle in a long sustain;
		// the sender idles here.
		write_register(sqoa_pkg::CFG_PHASE_STEP, 16'($urandom_range(1, 32767)));
		write_register(sqoa_pkg::CFG_DECAY_STEP, 16'($urandom_range(1000, 2000)));
		write_register(sqoa_pkg::CFG_SUSTAIN_LEVEL, 16'($urandom_range(15000, 30000)));
		write_register(sqoa_pkg::CFG_SUSTAIN_BUFFERS, 16'hFFFF);
		play_frames(300, 4, 56, 0);

		// Frozen phase, so the sign never changes; a sustain level at full
		// scale forces sustain if decay is still running. The receiver
		// stalls, with one long hold-off at the start.
		write_register(sqoa_pkg::CFG_PHASE_STEP, 16'd0);
		write_register(sqoa_pkg::CFG_SUSTAIN_LEVEL, 16'hFFFF);
		write_register(sqoa_pkg::CFG_DECAY_STEP, 16'hFFFF);
		write_register(sqoa_pkg::CFG_RELEASE_STEP, 16'hFFFF);
		stall_request <= 1'b1;
		play_frames(200, 3, 0, 56);

		// Smallest phase step; a zero sustain count sends the next update
		// straight through sustain into release, which acts at once.
		write_register(sqoa_pkg::CFG_PHASE_STEP, 16'd1);
		write_register(sqoa_pkg::CFG_ATTACK_STEP, 16'd0);
		write_register(sqoa_pkg::CFG_PEAK_LEVEL, 16'd0);
		write_register(sqoa_pkg::CFG_SUSTAIN_BUFFERS, 16'd0);
		write_register(sqoa_pkg::CFG_RELEASE_STEP, 16'($urandom_range(100, 400)));
		play_frames(300, 8, 37, 37);

		// Steeper release until the level clamps at zero and stays there;
		// also poke the unmapped index, which must change nothing.
		write_register(sqoa_pkg::CFG_PHASE_STEP, 16'($urandom_range(1, 16'hFFFF)));
		write_register(sqoa_pkg::CFG_RELEASE_STEP, 16'($urandom_range(2000, 6000)));
		write_register(CFG_UNMAPPED, 16'($urandom));
		write_register(sqoa_pkg::CFG_SUSTAIN_BUFFERS, 16'($urandom));
		play_frames(200, 3, 0, 0);

		// Allow for anything still in flight, then count leftovers.
		repeat (DRAIN_CYCLES) @(posedge clk);
		mismatches += expected_frames.size();
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
